[rtl/core/llh_pkg.sv]
// Package with the shared types and constants of the log2 latency histogram.
package llh_pkg;

  // Field widths of the item channels.
  localparam int unsigned LAT_W   = 64;
  localparam int unsigned BYTES_W = 32;
  localparam int unsigned FRAC_W  = 17;
  localparam int unsigned CNT_W   = 64;

  // A fraction of 1.0 in unsigned Q1.16.
  localparam logic [FRAC_W-1:0] PCT_ONE = 17'd65536;

  // Commands carried by an input item.
  typedef enum logic [1:0] {
    MODE_OK    = 2'd0,
    MODE_ERR   = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  // Sequencer states of the histogram unit.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REC_RD,
    ST_REC_UPD,
    ST_Q_MUL_HI,
    ST_Q_MUL_LO,
    ST_Q_RANK,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_RESP
  } state_t;

endpackage

[rtl/core/llh_if.sv]
// Valid/ready channel interfaces for the histogram's input and result items.
interface llh_in_if;
  logic                           valid;
  logic                           ready;
  llh_pkg::mode_t                 mode;
  logic [llh_pkg::LAT_W-1:0]      latency_in;
  logic [llh_pkg::BYTES_W-1:0]    byte_count_in;
  logic [llh_pkg::FRAC_W-1:0]     percentile_fraction;

  modport source (output valid, mode, latency_in, byte_count_in, percentile_fraction,
                  input ready);
  modport sink   (input valid, mode, latency_in, byte_count_in, percentile_fraction,
                  output ready);
endinterface

interface llh_out_if;
  logic                           valid;
  logic                           ready;
  logic [llh_pkg::CNT_W-1:0]      ok_total;
  logic [llh_pkg::CNT_W-1:0]      error_total;
  logic [llh_pkg::CNT_W-1:0]      byte_total;
  logic [llh_pkg::CNT_W-1:0]      percentile_us;

  modport source (output valid, ok_total, error_total, byte_total, percentile_us,
                  input ready);
  modport sink   (input valid, ok_total, error_total, byte_total, percentile_us,
                  output ready);
endinterface

[rtl/core/llh_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module llh_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/log2_latency_histogram_unit.sv]
// Top level of the log2 latency histogram unit.
//
// Items enter on req and each one yields exactly one result item on rsp.
// A record-success item bumps the success count, adds its bytes to the byte
// total and increments bucket floor(log2(latency_in + 1)), clamped to the top
// bucket. A record-error item bumps the error count, a clear item zeroes all
// counters and buckets, and a query item returns 2^i of the percentile bucket,
// or zero while no success is counted. Every result carries the counters as
// they stand after the item. One item is worked on at a time: a record reads
// its bucket from the bucket RAM and writes it back incremented before the
// next item is accepted. A query with successes counted forms the rank and
// then walks the buckets (at most BUCKETS): each bucket is one RAM read and
// one add-and-compare on the running sum. Reset and clear items empty the
// histogram through a row of per-bucket valid bits; no clearing pass is needed.
// A result waits in the output register while the receiver stalls, and the
// next item is accepted meanwhile; its result is held until the slot frees.
module log2_latency_histogram_unit #(
  parameter int unsigned BUCKETS = 64
) (
  input  logic         clk,
  input  logic         rst,
  llh_in_if.sink       req,
  llh_out_if.source    rsp
);

  localparam int unsigned IDX_W = $clog2(BUCKETS);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(BUCKETS - 1);
  localparam logic [5:0] LAST6 = 6'(BUCKETS - 1);

  // Control and counter state.
  llh_pkg::state_t                 state, state_next;
  logic [BUCKETS-1:0]              valid, valid_next;
  logic [llh_pkg::CNT_W-1:0]       ok_cnt, ok_cnt_next;
  logic [llh_pkg::CNT_W-1:0]       err_cnt, err_cnt_next;
  logic [llh_pkg::CNT_W-1:0]       byte_cnt, byte_cnt_next;
  logic                            out_valid, out_valid_next;

  // Working registers of the current item.
  logic [llh_pkg::LAT_W-1:0]       lat_inc, lat_inc_next;
  logic [llh_pkg::BYTES_W-1:0]     bytes, bytes_next;
  logic [IDX_W-1:0]                idx, idx_next;
  logic [llh_pkg::CNT_W-1:0]       n_reg, n_reg_next;
  logic [llh_pkg::FRAC_W-1:0]      p_reg, p_reg_next;
  logic [48:0]                     prod_hi, prod_hi_next;
  logic [48:0]                     prod_lo, prod_lo_next;
  logic [llh_pkg::CNT_W-1:0]       rank, rank_next;
  logic [llh_pkg::CNT_W-1:0]       cum, cum_next;
  logic [llh_pkg::CNT_W-1:0]       pct, pct_next;

  // Output register.
  logic [llh_pkg::CNT_W-1:0]       out_ok, out_ok_next;
  logic [llh_pkg::CNT_W-1:0]       out_err, out_err_next;
  logic [llh_pkg::CNT_W-1:0]       out_bytes, out_bytes_next;
  logic [llh_pkg::CNT_W-1:0]       out_pct, out_pct_next;

  // Bucket RAM ports.
  logic                            ram_we;
  logic [IDX_W-1:0]                ram_waddr;
  logic [llh_pkg::CNT_W-1:0]       ram_wdata;
  logic [IDX_W-1:0]                ram_raddr;
  logic [llh_pkg::CNT_W-1:0]       ram_rdata;

  // Datapath helpers.
  logic [5:0]                      lead6;
  logic [IDX_W-1:0]                rec_idx;
  logic [31:0]                     mul_a;
  logic [48:0]                     mul_prod;
  logic [llh_pkg::CNT_W-1:0]       bucket_val;
  logic [llh_pkg::CNT_W-1:0]       cum_sum;

  llh_ram #(
    .WIDTH (llh_pkg::CNT_W),
    .DEPTH (BUCKETS)
  ) u_buckets (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Value 2^i reported for bucket i; the top bucket reports 2^(BUCKETS-1).
  function automatic logic [llh_pkg::CNT_W-1:0] bucket_bound(input logic [IDX_W-1:0] i);
    bucket_bound = llh_pkg::CNT_W'(1) << i;
  endfunction

  // Highest set bit of lat_inc (latency_in + 1), clamped to the top bucket.
  always_comb begin
    lead6 = '0;
    for (int b = 1; b < 64; b++) begin
      if (lat_inc[b]) begin
        lead6 = 6'(b);
      end
    end
    if (lead6 > LAST6) begin
      rec_idx = LAST;
    end else begin
      rec_idx = lead6[IDX_W-1:0];
    end
  end

  // One 32 by 17 multiplier shared by both halves of the rank product.
  assign mul_a    = (state == llh_pkg::ST_Q_MUL_HI) ? n_reg[63:32] : n_reg[31:0];
  assign mul_prod = 49'(mul_a) * 49'(p_reg);

  // A bucket never written since reset or clear reads as zero.
  assign bucket_val = valid[idx] ? ram_rdata : '0;
  assign cum_sum    = cum + bucket_val;

  assign ram_raddr = (state == llh_pkg::ST_REC_RD) ? rec_idx : idx;
  assign ram_waddr = idx;
  assign ram_wdata = bucket_val + 64'd1;
  assign ram_we    = (state == llh_pkg::ST_REC_UPD);

  assign req.ready         = (state == llh_pkg::ST_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.ok_total      = out_ok;
  assign rsp.error_total   = out_err;
  assign rsp.byte_total    = out_bytes;
  assign rsp.percentile_us = out_pct;

  // Sequencer: next state and register updates.
  always_comb begin
    state_next     = state;
    valid_next     = valid;
    ok_cnt_next    = ok_cnt;
    err_cnt_next   = err_cnt;
    byte_cnt_next  = byte_cnt;
    out_valid_next = out_valid;
    lat_inc_next   = lat_inc;
    bytes_next     = bytes;
    idx_next       = idx;
    n_reg_next     = n_reg;
    p_reg_next     = p_reg;
    prod_hi_next   = prod_hi;
    prod_lo_next   = prod_lo;
    rank_next      = rank;
    cum_next       = cum;
    pct_next       = pct;
    out_ok_next    = out_ok;
    out_err_next   = out_err;
    out_bytes_next = out_bytes;
    out_pct_next   = out_pct;

    // The receiver takes the held result.
    if (rsp.ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      llh_pkg::ST_IDLE: begin
        if (req.valid) begin
          lat_inc_next = req.latency_in + 64'd1;
          bytes_next   = req.byte_count_in;
          pct_next     = '0;
          unique case (req.mode)
            llh_pkg::MODE_OK: begin
              state_next = llh_pkg::ST_REC_RD;
            end
            llh_pkg::MODE_ERR: begin
              err_cnt_next = err_cnt + 64'd1;
              state_next   = llh_pkg::ST_RESP;
            end
            llh_pkg::MODE_QUERY: begin
              if (ok_cnt == '0) begin
                state_next = llh_pkg::ST_RESP;
              end else begin
                n_reg_next = ok_cnt - 64'd1;
                p_reg_next = (req.percentile_fraction > llh_pkg::PCT_ONE) ?
                             llh_pkg::PCT_ONE : req.percentile_fraction;
                state_next = llh_pkg::ST_Q_MUL_HI;
              end
            end
            llh_pkg::MODE_CLEAR: begin
              valid_next    = '0;
              ok_cnt_next   = '0;
              err_cnt_next  = '0;
              byte_cnt_next = '0;
              state_next    = llh_pkg::ST_RESP;
            end
          endcase
        end
      end

      // Bucket read is issued at the encoded index.
      llh_pkg::ST_REC_RD: begin
        idx_next   = rec_idx;
        state_next = llh_pkg::ST_REC_UPD;
      end

      // Write back the incremented bucket and bump the counters.
      llh_pkg::ST_REC_UPD: begin
        valid_next[idx] = 1'b1;
        ok_cnt_next     = ok_cnt + 64'd1;
        byte_cnt_next   = byte_cnt + 64'(bytes);
        state_next      = llh_pkg::ST_RESP;
      end

      llh_pkg::ST_Q_MUL_HI: begin
        prod_hi_next = mul_prod;
        state_next   = llh_pkg::ST_Q_MUL_LO;
      end

      llh_pkg::ST_Q_MUL_LO: begin
        prod_lo_next = mul_prod;
        state_next   = llh_pkg::ST_Q_RANK;
      end

      // rank = floor(n * p / 65536), assembled from the two partial products.
      llh_pkg::ST_Q_RANK: begin
        rank_next  = {prod_hi[47:0], 16'b0} + {31'b0, prod_lo[48:16]};
        cum_next   = '0;
        idx_next   = '0;
        state_next = llh_pkg::ST_SCAN_RD;
      end

      llh_pkg::ST_SCAN_RD: begin
        state_next = llh_pkg::ST_SCAN_CHK;
      end

      // Add the bucket to the running sum and stop at the first one past rank.
      llh_pkg::ST_SCAN_CHK: begin
        if (cum_sum > rank) begin
          pct_next   = bucket_bound(idx);
          state_next = llh_pkg::ST_RESP;
        end else if (idx == LAST) begin
          pct_next   = bucket_bound(LAST);
          state_next = llh_pkg::ST_RESP;
        end else begin
          cum_next   = cum_sum;
          idx_next   = idx + 1'b1;
          state_next = llh_pkg::ST_SCAN_RD;
        end
      end

      // Load the result once the output register is free.
      llh_pkg::ST_RESP: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next = 1'b1;
          out_ok_next    = ok_cnt;
          out_err_next   = err_cnt;
          out_bytes_next = byte_cnt;
          out_pct_next   = pct;
          state_next     = llh_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = llh_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and counters reset; working and output payload do not.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= llh_pkg::ST_IDLE;
      valid     <= '0;
      ok_cnt    <= '0;
      err_cnt   <= '0;
      byte_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      valid     <= valid_next;
      ok_cnt    <= ok_cnt_next;
      err_cnt   <= err_cnt_next;
      byte_cnt  <= byte_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    lat_inc   <= lat_inc_next;
    bytes     <= bytes_next;
    idx       <= idx_next;
    n_reg     <= n_reg_next;
    p_reg     <= p_reg_next;
    prod_hi   <= prod_hi_next;
    prod_lo   <= prod_lo_next;
    rank      <= rank_next;
    cum       <= cum_next;
    pct       <= pct_next;
    out_ok    <= out_ok_next;
    out_err   <= out_err_next;
    out_bytes <= out_bytes_next;
    out_pct   <= out_pct_next;
  end

endmodule

[dv/testbench.sv]
// Self-checking testbench for the log2 latency histogram unit.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned BUCKETS      = 64;
  localparam int unsigned RANDOM_ITEMS = 850;
  // No idling once the backlog is this short.
  localparam int unsigned QUIET_TAIL   = 120;
  // Run-out after the last result, longer than the longest query.
  localparam int unsigned DRAIN_CYCLES = 200;

  typedef struct {
    llh_pkg::mode_t                 mode;
    logic [llh_pkg::LAT_W-1:0]      latency_in;
    logic [llh_pkg::BYTES_W-1:0]    byte_count_in;
    logic [llh_pkg::FRAC_W-1:0]     percentile_fraction;
  } stim_item_t;

  typedef struct {
    logic [llh_pkg::CNT_W-1:0] ok_total;
    logic [llh_pkg::CNT_W-1:0] error_total;
    logic [llh_pkg::CNT_W-1:0] byte_total;
    logic [llh_pkg::CNT_W-1:0] percentile_us;
  } totals_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  llh_in_if  req ();
  llh_out_if rsp ();

  log2_latency_histogram_unit #(.BUCKETS(BUCKETS)) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Predicted histogram state.
  logic [llh_pkg::CNT_W-1:0] hist_bucket [BUCKETS];
  logic [llh_pkg::CNT_W-1:0] hist_ok;
  logic [llh_pkg::CNT_W-1:0] hist_err;
  logic [llh_pkg::CNT_W-1:0] hist_bytes;

  stim_item_t  pending_items [$];
  totals_t     totals_due [$];
  stim_item_t  next_item;
  totals_t     due;
  logic        req_taken = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  int unsigned error_count = 0;
  int unsigned results_seen = 0;
  int unsigned mode_seen [4] = '{0, 0, 0, 0};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Apply one command to the predicted state and return the totals it reports.
  function automatic totals_t histogram_update(llh_pkg::mode_t mode,
                                               logic [llh_pkg::LAT_W-1:0] latency,
                                               logic [llh_pkg::BYTES_W-1:0] nbytes,
                                               logic [llh_pkg::FRAC_W-1:0] frac);
    totals_t                    res;
    logic [llh_pkg::LAT_W-1:0]  lat_plus;
    int unsigned                idx;
    logic [80:0]                product;
    logic [llh_pkg::CNT_W-1:0]  rank;
    logic [llh_pkg::CNT_W-1:0]  running;
    logic [llh_pkg::FRAC_W-1:0] p;
    logic                       found;
    res.percentile_us = '0;
    case (mode)
      llh_pkg::MODE_OK: begin
        hist_ok    = hist_ok + 64'd1;
        hist_bytes = hist_bytes + {32'd0, nbytes};
        // The sum lat_plus wraps to zero for an all-ones input, which lands in bucket 0.
        lat_plus = latency + 64'd1;
        idx = 0;
        for (int b = 0; b < 64; b++) begin
          if (lat_plus[b]) idx = b;
        end
        if (idx > BUCKETS - 1) idx = BUCKETS - 1;
        hist_bucket[idx] = hist_bucket[idx] + 64'd1;
      end
      llh_pkg::MODE_ERR: begin
        hist_err = hist_err + 64'd1;
      end
      llh_pkg::MODE_QUERY: begin
        if (hist_ok != '0) begin
          p = (frac > llh_pkg::PCT_ONE) ? llh_pkg::PCT_ONE : frac;
          product = {17'd0, hist_ok - 64'd1} * {64'd0, p};
          rank = product[79:16];
          running = '0;
          found = 1'b0;
          for (int b = 0; b < BUCKETS; b++) begin
            running = running + hist_bucket[b];
            if (!found && running > rank) begin
              found = 1'b1;
              res.percentile_us = (b >= 63) ? (64'd1 << 63) : (64'd1 << b);
            end
          end
          // With no bucket found the top bucket's bound is reported.
          if (!found) begin
            res.percentile_us = (BUCKETS >= 64) ? (64'd1 << 63) : (64'd1 << (BUCKETS - 1));
          end
        end
      end
      default: begin
        for (int b = 0; b < BUCKETS; b++) hist_bucket[b] = '0;
        hist_ok    = '0;
        hist_err   = '0;
        hist_bytes = '0;
      end
    endcase
    res.ok_total    = hist_ok;
    res.error_total = hist_err;
    res.byte_total  = hist_bytes;
    return res;
  endfunction

  function automatic void check_field(string name, logic [llh_pkg::CNT_W-1:0] want,
                                      logic [llh_pkg::CNT_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Acceptance of an input item, seen by the driver at the next falling edge.
  always @(posedge clk) begin
    req_taken <= req.valid && req.ready;
  end

  // Compare each result item with the oldest prediction, then predict new items.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        results_seen++;
        if (totals_due.size() == 0) begin
          $error("Result item arrived with no prediction pending");
          error_count++;
        end else begin
          due = totals_due.pop_front();
          check_field("ok_total", due.ok_total, rsp.ok_total);
          check_field("error_total", due.error_total, rsp.error_total);
          check_field("byte_total", due.byte_total, rsp.byte_total);
          check_field("percentile_us", due.percentile_us, rsp.percentile_us);
        end
      end
      if (req.valid && req.ready) begin
        mode_seen[req.mode]++;
        totals_due.push_back(histogram_update(req.mode, req.latency_in,
                                              req.byte_count_in, req.percentile_fraction));
      end
    end
  end

  // Input driver: presents queued items, with random idle bursts.
  always @(negedge clk) begin
    if (!rst) begin
      if (req.valid && !req_taken) begin
        // Item still waiting for acceptance; hold it.
      end else if (send_gap > 0) begin
        req.valid <= 1'b0;
        send_gap  <= send_gap - 1;
      end else if (pending_items.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        req.valid <= 1'b0;
        send_gap  <= $urandom_range(0, 18);
      end else if (pending_items.size() > 0) begin
        next_item = pending_items.pop_front();
        req.valid               <= 1'b1;
        req.mode                <= next_item.mode;
        req.latency_in          <= next_item.latency_in;
        req.byte_count_in       <= next_item.byte_count_in;
        req.percentile_fraction <= next_item.percentile_fraction;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stall bursts while the backlog is long.
  always @(negedge clk) begin
    if (!rst) begin
      if (recv_stall > 0) begin
        rsp.ready  <= 1'b0;
        recv_stall <= recv_stall - 1;
      end else if (pending_items.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        rsp.ready  <= 1'b0;
        recv_stall <= $urandom_range(0, 18);
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Reset of the prediction, the inputs and the block.
  initial begin
    for (int b = 0; b < BUCKETS; b++) hist_bucket[b] = '0;
    hist_ok    = '0;
    hist_err   = '0;
    hist_bytes = '0;
    req.valid               = 1'b0;
    req.mode                = llh_pkg::MODE_OK;
    req.latency_in          = '0;
    req.byte_count_in       = '0;
    req.percentile_fraction = '0;
    rsp.ready               = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Stimulus and end of run.
  initial begin
    stim_item_t it;
    int unsigned pick;

    // Directed items: empty query, latency extremes, fraction extremes, clear.
    pending_items.push_back('{llh_pkg::MODE_QUERY, 64'd0, 32'd0, 17'd65536});
    pending_items.push_back('{llh_pkg::MODE_OK, 64'd0, 32'd0, 17'd0});
    pending_items.push_back('{llh_pkg::MODE_OK, 64'hFFFF_FFFF_FFFF_FFFF,
                              32'hFFFF_FFFF, 17'h1FFFF});
    pending_items.push_back('{llh_pkg::MODE_OK, 64'd1, 32'd1, 17'd0});
    pending_items.push_back('{llh_pkg::MODE_OK, 64'h8000_0000_0000_0000, 32'd100, 17'd0});
    pending_items.push_back('{llh_pkg::MODE_OK, 64'h7FFF_FFFF_FFFF_FFFF, 32'd7, 17'd0});
    pending_items.push_back('{llh_pkg::MODE_OK, 64'h3FFF_FFFF_FFFF_FFFF, 32'd9, 17'd0});
    pending_items.push_back('{llh_pkg::MODE_OK, 64'hFFFF_FFFF_FFFF_FFFE, 32'd3, 17'd0});
    pending_items.push_back('{llh_pkg::MODE_OK, 64'd1000, 32'h8000_0000, 17'd0});
    pending_items.push_back('{llh_pkg::MODE_ERR, 64'hFFFF_FFFF_FFFF_FFFF,
                              32'hFFFF_FFFF, 17'h1FFFF});
    pending_items.push_back('{llh_pkg::MODE_ERR, 64'd0, 32'd0, 17'd0});
    pending_items.push_back('{llh_pkg::MODE_QUERY, 64'd0, 32'd0, 17'd0});
    pending_items.push_back('{llh_pkg::MODE_QUERY, 64'd0, 32'd0, 17'd65536});
    pending_items.push_back('{llh_pkg::MODE_QUERY, 64'd0, 32'd0, 17'd32768});
    pending_items.push_back('{llh_pkg::MODE_QUERY, 64'd0, 32'd0, 17'h1FFFF});
    pending_items.push_back('{llh_pkg::MODE_QUERY, 64'd0, 32'd0, 17'd65537});
    pending_items.push_back('{llh_pkg::MODE_QUERY, 64'd0, 32'd0, 17'd1});
    pending_items.push_back('{llh_pkg::MODE_CLEAR, 64'h1234, 32'd5, 17'd5});
    pending_items.push_back('{llh_pkg::MODE_QUERY, 64'd0, 32'd0, 17'd65536});
    pending_items.push_back('{llh_pkg::MODE_ERR, 64'd0, 32'd0, 17'd0});
    pending_items.push_back('{llh_pkg::MODE_OK, 64'd5, 32'd12, 17'd0});
    pending_items.push_back('{llh_pkg::MODE_QUERY, 64'd0, 32'd0, 17'h1FFFF});
    pending_items.push_back('{llh_pkg::MODE_QUERY, 64'd0, 32'd0, 17'd0});

    // Random items: mostly records with queries between, rare clears.
    repeat (RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) it.mode = llh_pkg::MODE_OK;
      else if (pick < 75) it.mode = llh_pkg::MODE_ERR;
      else if (pick < 97) it.mode = llh_pkg::MODE_QUERY;
      else it.mode = llh_pkg::MODE_CLEAR;
      // Spread latencies over every bucket, with the all-ones corner now and then.
      it.latency_in = {$urandom, $urandom} >> $urandom_range(0, 63);
      if ($urandom_range(0, 19) == 0)
        it.latency_in = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 1));
      it.byte_count_in = $urandom >> $urandom_range(0, 31);
      pick = $urandom_range(0, 9);
      if (pick == 0) it.percentile_fraction = 17'($urandom_range(65537, 131071));
      else if (pick == 1)
        it.percentile_fraction = ($urandom_range(0, 1) == 0) ? 17'd0 : llh_pkg::PCT_ONE;
      else it.percentile_fraction = 17'($urandom_range(0, 65536));
      pending_items.push_back(it);
    end

    wait (!rst);
    wait (pending_items.size() == 0 && !req.valid);
    wait (totals_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d records, %0d errors, %0d queries and %0d clears.",
             mode_seen[llh_pkg::MODE_OK], mode_seen[llh_pkg::MODE_ERR],
             mode_seen[llh_pkg::MODE_QUERY], mode_seen[llh_pkg::MODE_CLEAR]);
    $display("Checked %0d result items; %0d mismatches found.", results_seen, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20_000_000;
    $display("Timed out waiting for the histogram unit.");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
